### hdl/bt_pkg.sv
// Shared constants, types and helper functions for the block transposition cipher.
`timescale 1ns / 1ps

package bt_pkg;

  // Field and register widths
  localparam int BYTE_W   = 8;
  localparam int CNT_W    = 4;
  localparam int PERM_N   = 8;
  localparam int PERM_W   = 3;
  localparam int CFG_W    = 24;
  localparam int CFG_IDX_W = 2;

  // Default block buffer depth
  localparam int MAX_BLOCK_DEF = 8;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PERM_TABLE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DECRYPT_MODE = 2'd2;

  // Reset values of the registers
  localparam logic [CNT_W-1:0]  BLOCK_SIZE_RST = 4'd8;
  localparam logic [CFG_W-1:0]  PERM_TABLE_RST = 24'hFAC688;

  // Byte used to pad a short final block
  localparam logic [BYTE_W-1:0] PAD_BYTE = 8'h20;

  // Tag that travels with one buffer read
  typedef struct packed {
    logic pad;
    logic blk_end;
    logic msg_end;
  } rd_tag_t;

  // Extract table entry k
  function automatic logic [PERM_W-1:0] perm_entry(input logic [CFG_W-1:0] tbl,
                                                   input logic [PERM_W-1:0] k);
    return tbl[k*PERM_W +: PERM_W];
  endfunction

  // Effective block size, clamped to 1..lim
  function automatic logic [CNT_W-1:0] eff_size(input logic [CNT_W-1:0] bsz,
                                                input logic [CNT_W-1:0] lim);
    logic [CNT_W-1:0] bs;
    bs = bsz;
    if (bs == '0) bs = {{(CNT_W-1){1'b0}}, 1'b1};
    if (bs > lim) bs = lim;
    return bs;
  endfunction

  // Source position for output j; {found, index}
  function automatic logic [PERM_W:0] src_select(input logic [CFG_W-1:0] tbl,
                                                 input logic [CNT_W-1:0] j,
                                                 input logic [CNT_W-1:0] bs,
                                                 input logic             dec);
    logic [PERM_W-1:0] e;
    logic              found;
    logic [PERM_W-1:0] idx;
    found = 1'b0;
    idx   = '0;
    if (dec) begin
      // Highest matching position wins
      for (int i = 0; i < PERM_N; i++) begin
        if ((CNT_W'(i) < bs) &&
            ({1'b0, perm_entry(tbl, PERM_W'(i))} == j)) begin
          found = 1'b1;
          idx   = PERM_W'(i);
        end
      end
    end else begin
      e = perm_entry(tbl, j[PERM_W-1:0]);
      if ({1'b0, e} < bs) begin
        found = 1'b1;
        idx   = e;
      end
    end
    return {found, idx};
  endfunction

endpackage

### hdl/bt_buf.sv
// Block buffer memory: one write port, one read port with registered read data.
`timescale 1ns / 1ps

module bt_buf import bt_pkg::*; #(
  parameter int DEPTH = MAX_BLOCK_DEF,
  parameter int AW    = $clog2(MAX_BLOCK_DEF)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  logic [BYTE_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  output logic [BYTE_W-1:0] rd_data
);

  logic [BYTE_W-1:0] mem [DEPTH];
  logic [BYTE_W-1:0] rd_data_r;

  // Store one byte
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read one byte, hold it otherwise
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### hdl/bt_ctrl.sv
// Fill and emit sequencer: writes incoming bytes and issues permuted reads.
`timescale 1ns / 1ps

module bt_ctrl import bt_pkg::*; #(
  parameter int MAX_BLOCK = MAX_BLOCK_DEF,
  parameter int AW        = $clog2(MAX_BLOCK_DEF)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [CNT_W-1:0]  block_size,
  input  logic [CFG_W-1:0]  perm_table,
  input  logic              decrypt_mode,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [BYTE_W-1:0] in_data_byte,
  input  logic              in_end_of_message,
  input  logic              issue_ok,
  output logic              wr_en,
  output logic [AW-1:0]     wr_addr,
  output logic [BYTE_W-1:0] wr_data,
  output logic              rd_en,
  output logic [AW-1:0]     rd_addr,
  output rd_tag_t           rd_tag
);

  localparam int LIM = (MAX_BLOCK < PERM_N) ? MAX_BLOCK : PERM_N;
  localparam logic [CNT_W-1:0] LIM_C = CNT_W'(LIM);

  localparam logic ST_FILL = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  logic             state_r,  state_nxt;
  logic [CNT_W-1:0] fill_r,   fill_nxt;
  logic [CNT_W-1:0] len_r,    len_nxt;
  logic [CNT_W-1:0] j_r,      j_nxt;
  logic             last_r,   last_nxt;

  logic [CNT_W-1:0] bs;
  logic [CNT_W-1:0] pos;
  logic [CNT_W-1:0] pos_inc;
  logic             accept;
  logic             blk_done;
  logic [PERM_W:0]  sel;
  logic             last_issue;

  assign bs       = eff_size(block_size, LIM_C);
  assign in_stall = (state_r == ST_EMIT);
  assign accept   = in_valid && !in_stall;

  // Write position, clamped when the block size shrank under a partial block
  assign pos      = (fill_r >= bs) ? (bs - 1'b1) : fill_r;
  assign pos_inc  = pos + 1'b1;
  assign blk_done = (pos_inc >= bs) || in_end_of_message;

  assign wr_en   = accept;
  assign wr_addr = AW'(pos);
  assign wr_data = in_data_byte;

  // Pick source position for the current output
  assign sel        = src_select(perm_table, j_r, bs, decrypt_mode);
  assign last_issue = (j_r == bs - 1'b1);

  assign rd_en          = (state_r == ST_EMIT) && issue_ok;
  assign rd_addr        = AW'(sel[PERM_W-1:0]);
  assign rd_tag.pad     = !sel[PERM_W] || ({1'b0, sel[PERM_W-1:0]} >= len_r);
  assign rd_tag.blk_end = last_issue;
  assign rd_tag.msg_end = last_issue && last_r;

  // Next-state logic
  always_comb begin
    state_nxt = state_r;
    fill_nxt  = fill_r;
    len_nxt   = len_r;
    j_nxt     = j_r;
    last_nxt  = last_r;
    case (state_r)
      ST_FILL: begin
        if (accept) begin
          if (blk_done) begin
            state_nxt = ST_EMIT;
            fill_nxt  = '0;
            len_nxt   = pos_inc;
            j_nxt     = '0;
            last_nxt  = in_end_of_message;
          end else begin
            fill_nxt = pos_inc;
          end
        end
      end
      ST_EMIT: begin
        if (rd_en) begin
          j_nxt = j_r + 1'b1;
          if (last_issue) begin
            state_nxt = ST_FILL;
          end
        end
      end
      default: state_nxt = ST_FILL;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_FILL;
      fill_r  <= '0;
      len_r   <= '0;
      j_r     <= '0;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      len_r   <= len_nxt;
      j_r     <= j_nxt;
      last_r  <= last_nxt;
    end
  end

endmodule

### hdl/block_transposition_cipher.sv
// Top level of the block transposition cipher: registers, buffer, sequencer, output stage.
`timescale 1ns / 1ps

// Bytes are taken one per cycle into a block buffer memory until a block of
// block_size bytes is complete, or a byte flagged end_of_message closes a short
// block (missing positions read as spaces). The block is then sent out permuted,
// one byte per cycle unless out_stall holds the output, by reading the buffer's
// single read port in output order; the input is stalled while the block is sent
// out. Each permuted byte passes through the buffer's read data register and then
// the output register. Configuration writes are taken at any time but belong
// between messages or blocks, with no output pending.

module block_transposition_cipher import bt_pkg::*; #(
  parameter int MAX_BLOCK = MAX_BLOCK_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [BYTE_W-1:0]    in_data_byte,
  input  logic                 in_end_of_message,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [BYTE_W-1:0]    out_out_byte,
  output logic                 out_block_end,
  output logic                 out_message_end
);

  localparam int AW = $clog2(MAX_BLOCK);

  logic [CNT_W-1:0]  block_size_r;
  logic [CFG_W-1:0]  perm_table_r;
  logic              decrypt_mode_r;

  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [BYTE_W-1:0] wr_data;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic [BYTE_W-1:0] rd_data;
  rd_tag_t           rd_tag;

  logic              rd_vld_r;
  rd_tag_t           tag_r;
  logic              out_valid_r;
  logic [BYTE_W-1:0] out_byte_r;
  logic              out_blk_end_r;
  logic              out_msg_end_r;
  logic              out_adv;
  logic              issue_ok;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_size_r   <= BLOCK_SIZE_RST;
      perm_table_r   <= PERM_TABLE_RST;
      decrypt_mode_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BLOCK_SIZE:   block_size_r   <= cfg_data[CNT_W-1:0];
        REG_PERM_TABLE:   perm_table_r   <= cfg_data;
        REG_DECRYPT_MODE: decrypt_mode_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  bt_ctrl #(
    .MAX_BLOCK (MAX_BLOCK),
    .AW        (AW)
  ) u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .block_size        (block_size_r),
    .perm_table        (perm_table_r),
    .decrypt_mode      (decrypt_mode_r),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_data_byte      (in_data_byte),
    .in_end_of_message (in_end_of_message),
    .issue_ok          (issue_ok),
    .wr_en             (wr_en),
    .wr_addr           (wr_addr),
    .wr_data           (wr_data),
    .rd_en             (rd_en),
    .rd_addr           (rd_addr),
    .rd_tag            (rd_tag)
  );

  bt_buf #(
    .DEPTH (MAX_BLOCK),
    .AW    (AW)
  ) u_buf (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Output register frees when empty or taken; a read may issue when its slot frees
  assign out_adv  = !out_valid_r || !out_stall;
  assign issue_ok = !rd_vld_r || out_adv;

  // Track the read in flight alongside the memory's data register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else if (rd_en) begin
      rd_vld_r <= 1'b1;
    end else if (out_adv) begin
      rd_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      tag_r <= rd_tag;
    end
  end

  // Output stage: hold while stalled, advance otherwise
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= rd_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && rd_vld_r) begin
      out_byte_r    <= tag_r.pad ? PAD_BYTE : rd_data;
      out_blk_end_r <= tag_r.blk_end;
      out_msg_end_r <= tag_r.msg_end;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_out_byte    = out_byte_r;
  assign out_block_end   = out_blk_end_r;
  assign out_message_end = out_msg_end_r;

endmodule
